@@ src/chained_hash_integer_set_defines.svh @@
// assertion macros for the chained hash integer set
`ifndef CHAINED_HASH_INTEGER_SET_DEFINES_SVH
`define CHAINED_HASH_INTEGER_SET_DEFINES_SVH

// property that holds at every edge outside reset
`define CHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next edge
`define CHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/chs_pkg.sv @@
// package: types, constants and command/status structs of the hash set
package chs_pkg;

  localparam int Buckets     = 16;
  localparam int PoolEntries = 256;
  localparam int BucketW     = $clog2(Buckets);
  localparam int PoolW       = $clog2(PoolEntries);
  localparam int CountW      = $clog2(PoolEntries + 1);

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_CONTAINS = 2'd1,
    KIND_GET_NTH  = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [63:0] value;
    logic [7:0]        element_index;
  } chs_in_t;

  typedef struct packed {
    logic              hit;
    logic signed [63:0] element_value;
    logic [8:0]        element_count;
    logic              pool_full;
  } chs_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_READ,
    ST_CHECK,
    ST_INSERT,
    ST_SCAN,
    ST_DONE
  } chs_state_t;

  typedef struct packed {
    logic load;
    logic head_rd;
    logic pool_rd;
    logic step;
    logic next_bucket;
    logic do_insert;
    logic do_clear;
    logic set_hit;
    logic set_full;
    logic set_elem;
    logic out_load;
  } chs_cmd_t;

  typedef struct packed {
    logic          bucket_used;
    logic          match;
    logic          has_next;
    logic          nth_hit;
    logic          pool_full;
    logic          n_in_range;
    logic [1:0]    kind;
  } chs_sts_t;

endpackage

@@ src/chs_datapath.sv @@
// datapath: bucket table, entry pool, chain walk registers and result word
module chs_datapath
  import chs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  chs_in_t  in_word,
  input  chs_cmd_t cmd,
  output chs_sts_t sts,
  output chs_out_t out_word
);
  `include "chained_hash_integer_set_defines.svh"

  logic [PoolW-1:0] head_mem [Buckets];
  logic [63:0]      val_mem  [PoolEntries];
  logic [PoolW-1:0] next_mem [PoolEntries];
  logic             hasn_mem [PoolEntries];
  logic [Buckets-1:0] used_r;
  logic [CountW-1:0]  count_r;

  chs_in_t          req_r;
  logic [BucketW-1:0] bkt_r;
  logic [PoolW-1:0] ptr_r;
  logic [63:0]      rd_val_r;
  logic [PoolW-1:0] rd_next_r;
  logic             rd_hasn_r;
  logic [PoolW-1:0] head_q_r;
  logic [CountW-1:0] seen_r;
  logic             wk_hit_r;
  logic             wk_full_r;
  logic [63:0]      wk_elem_r;
  chs_out_t         out_r;

  logic [63:0]        mag;
  logic [BucketW-1:0] in_bkt;

  assign mag    = in_word.value[63] ? (64'd0 - in_word.value) : in_word.value;
  assign in_bkt = mag[BucketW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.head_rd) begin
      head_q_r <= head_mem[bkt_r];
    end
    if (cmd.pool_rd) begin
      rd_val_r  <= val_mem[ptr_r];
      rd_next_r <= next_mem[ptr_r];
      rd_hasn_r <= hasn_mem[ptr_r];
    end
    if (cmd.do_insert) begin
      val_mem[count_r[PoolW-1:0]]  <= req_r.value;
      next_mem[count_r[PoolW-1:0]] <= head_q_r;
      hasn_mem[count_r[PoolW-1:0]] <= used_r[bkt_r];
      head_mem[bkt_r]              <= count_r[PoolW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      count_r <= '0;
    end else if (cmd.do_clear) begin
      used_r  <= '0;
      count_r <= '0;
    end else if (cmd.do_insert) begin
      used_r[bkt_r] <= 1'b1;
      count_r       <= count_r + 1'b1;
    end
  end

  // working result built during the walk, copied to the result word when done
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= in_word;
      bkt_r     <= (in_word.kind == KIND_GET_NTH) ? '0 : in_bkt;
      seen_r    <= '0;
      wk_hit_r  <= 1'b0;
      wk_full_r <= 1'b0;
      wk_elem_r <= '0;
    end else begin
      if (cmd.head_rd && used_r[bkt_r]) begin
        ptr_r <= head_mem[bkt_r];
      end
      if (cmd.step) begin
        ptr_r  <= rd_next_r;
        seen_r <= seen_r + 1'b1;
      end
      if (cmd.next_bucket) begin
        bkt_r <= bkt_r + 1'b1;
      end
      if (cmd.set_hit)  wk_hit_r <= 1'b1;
      if (cmd.set_full) wk_full_r <= 1'b1;
      if (cmd.set_elem) wk_elem_r <= rd_val_r;
      if (cmd.out_load) begin
        out_r.hit           <= wk_hit_r;
        out_r.element_value <= wk_elem_r;
        out_r.element_count <= 9'(count_r);
        out_r.pool_full     <= wk_full_r;
      end
    end
  end

  assign sts.bucket_used = used_r[bkt_r];
  assign sts.match       = (rd_val_r == req_r.value);
  assign sts.has_next    = rd_hasn_r;
  assign sts.nth_hit     = (seen_r == CountW'(req_r.element_index));
  assign sts.pool_full   = (count_r >= CountW'(PoolEntries));
  assign sts.n_in_range  = (CountW'(req_r.element_index) < count_r);
  assign sts.kind        = req_r.kind;
  assign out_word        = out_r;

  `CHS_ASSERT(a_count_bound, count_r <= CountW'(PoolEntries), "count beyond pool size")
  `CHS_ASSERT_NEXT(a_insert_count, cmd.do_insert && !cmd.do_clear,
    count_r == $past(count_r) + 1'b1, "insert did not advance count")
  `CHS_ASSERT_NEXT(a_clear_empty, cmd.do_clear, count_r == '0 && used_r == '0,
    "clear left elements")
endmodule

@@ src/chs_control.sv @@
// controller: sequencing of lookup, insert, scan and clear
module chs_control
  import chs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  chs_sts_t sts,
  output chs_cmd_t cmd
);
  `include "chained_hash_integer_set_defines.svh"

  chs_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_HEAD;
      ST_HEAD: begin
        case (sts.kind)
          KIND_CLEAR: state_nxt = ST_DONE;
          KIND_GET_NTH: begin
            if (!sts.n_in_range) state_nxt = ST_DONE;
            else if (sts.bucket_used) state_nxt = ST_READ;
            else state_nxt = ST_HEAD;
          end
          default: state_nxt = sts.bucket_used ? ST_READ : ST_CHECK;
        endcase
      end
      ST_READ: state_nxt = (sts.kind == KIND_GET_NTH) ? ST_SCAN : ST_CHECK;
      ST_CHECK: begin
        if (sts.bucket_used && sts.match) state_nxt = ST_DONE;
        else if (sts.bucket_used && sts.has_next) state_nxt = ST_READ;
        else if (sts.kind == KIND_INSERT) state_nxt = ST_INSERT;
        else state_nxt = ST_DONE;
      end
      ST_INSERT: state_nxt = ST_DONE;
      ST_SCAN: begin
        if (sts.nth_hit) state_nxt = ST_DONE;
        else if (sts.has_next) state_nxt = ST_READ;
        else state_nxt = ST_HEAD;
      end
      ST_DONE: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: cmd.load = accept;
      ST_HEAD: begin
        cmd.head_rd  = 1'b1;
        cmd.do_clear = (sts.kind == KIND_CLEAR);
        if (sts.kind == KIND_GET_NTH && sts.n_in_range && !sts.bucket_used) begin
          cmd.next_bucket = 1'b1;
        end
      end
      ST_READ: cmd.pool_rd = 1'b1;
      ST_CHECK: begin
        if (sts.bucket_used && sts.match) begin
          cmd.set_hit = (sts.kind == KIND_CONTAINS);
        end else if (sts.bucket_used && sts.has_next) begin
          cmd.step = 1'b1;
        end else if (sts.kind == KIND_INSERT) begin
          if (sts.pool_full) cmd.set_full = 1'b1;
          else cmd.set_hit = 1'b1;
        end
      end
      ST_INSERT: cmd.do_insert = !sts.pool_full;
      ST_SCAN: begin
        if (sts.nth_hit) cmd.set_elem = 1'b1;
        else if (sts.has_next) cmd.step = 1'b1;
        else begin
          cmd.step = 1'b1;
          cmd.next_bucket = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CHS_ASSERT(a_one_write, !(cmd.do_insert && cmd.do_clear), "insert and clear together")
  `CHS_ASSERT_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r,
    "result word dropped while stalled")
  `CHS_ASSERT_NEXT(a_load_leaves_idle, cmd.load, state_r == ST_HEAD,
    "accepted word not started")
endmodule

@@ src/chained_hash_integer_set.sv @@
// top level: hash set of signed 64-bit integers with separate chaining
// One word at a time. An operation walks its bucket chain through the entry pool, reading
// and then comparing each entry; get-nth walks all buckets in order, skipping empty buckets,
// and steps through the entries up to the nth. The result register lets the next word be
// taken while a finished result waits. No clearing pass: the tables need none after reset.
module chained_hash_integer_set
  import chs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  chs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output chs_out_t out_data
);

  chs_cmd_t cmd;
  chs_sts_t sts;

  chs_control u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  chs_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_data)
  );

endmodule
